FILE: rtl/eco_pkg.sv
// Shared types and constants for the camera orientation block.
package eco_pkg;

	localparam int ANG_W = 25;
	localparam int Z_W = 36;
	localparam int XY_W = 34;
	localparam int FULL_TURN = 360 * 65536;
	localparam int HALF_TURN = 180 * 65536;
	localparam int QUARTER_TURN = 90 * 65536;
	localparam int PITCH_LIMIT = 89 * 65536;
	localparam longint Z_HALF = 64'sd180 <<< 24;
	localparam longint Z_QUARTER = 64'sd90 <<< 24;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic signed [XY_W-1:0] Q30_ONE = 34'sd1073741824;

	function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0: atan_entry = 36'sd754974720;
			5'd1: atan_entry = 36'sd445687602;
			5'd2: atan_entry = 36'sd235489088;
			5'd3: atan_entry = 36'sd119537938;
			5'd4: atan_entry = 36'sd60000934;
			5'd5: atan_entry = 36'sd30029717;
			5'd6: atan_entry = 36'sd15018523;
			5'd7: atan_entry = 36'sd7509720;
			5'd8: atan_entry = 36'sd3754917;
			5'd9: atan_entry = 36'sd1877466;
			5'd10: atan_entry = 36'sd938734;
			5'd11: atan_entry = 36'sd469367;
			5'd12: atan_entry = 36'sd234684;
			5'd13: atan_entry = 36'sd117342;
			5'd14: atan_entry = 36'sd58671;
			5'd15: atan_entry = 36'sd29335;
			5'd16: atan_entry = 36'sd14668;
			5'd17: atan_entry = 36'sd7334;
			5'd18: atan_entry = 36'sd3667;
			5'd19: atan_entry = 36'sd1833;
			5'd20: atan_entry = 36'sd917;
			5'd21: atan_entry = 36'sd458;
			5'd22: atan_entry = 36'sd229;
			5'd23: atan_entry = 36'sd115;
			5'd24: atan_entry = 36'sd57;
			5'd25: atan_entry = 36'sd29;
			5'd26: atan_entry = 36'sd14;
			5'd27: atan_entry = 36'sd7;
			5'd28: atan_entry = 36'sd4;
			5'd29: atan_entry = 36'sd2;
			5'd30: atan_entry = 36'sd1;
			default: atan_entry = 36'sd0;
		endcase
	endfunction

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // take input word, form raw angle sums
		logic wrap;       // wrap or clamp the raw sums into the angles
		logic cordic_init;
		logic cordic_sel; // 0 yaw, 1 pitch
		logic cordic_step;
		logic save_yaw;
		logic save_pitch;
		logic mul_start;
		logic mul_step;
		logic finish;
	} eco_cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic mul_done;
	} eco_sts_t;

endpackage

FILE: rtl/eco_datapath.sv
// Datapath: angle update, shared CORDIC unit, shared product unit, vector rounding.
module eco_datapath #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eco_pkg::eco_cmd_t    cmd,
	output eco_pkg::eco_sts_t    sts,
	input  logic [17:0]          sensitivity,
	input  logic signed [15:0]   delta_x,
	input  logic signed [15:0]   delta_y,
	input  logic                 limit_pitch,
	output logic [194:0]         result
);
	localparam int XW = eco_pkg::XY_W;
	localparam int ZW = eco_pkg::Z_W;
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

	logic [24:0] yaw_q;
	logic signed [24:0] pitch_q;
	logic signed [35:0] yraw_q, praw_q;
	logic lim_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic flip_q;
	logic [STEP_W-1:0] step_q;
	logic signed [XW-1:0] sy_q, cy_q, sp_q, cp_q;
	logic degen_q;
	logic [2:0] mul_idx_q;
	logic signed [XW-1:0] p_q [4];

	// One turn is 45 * 2^19 units: keep the low 19 bits and reduce the rest
	// modulo 45 with a reciprocal multiply (exact for operands below 2^16).
	function automatic logic [24:0] wrap_turn(input logic signed [35:0] v);
		logic signed [16:0] hi;
		logic [15:0] a;
		logic [31:0] prod;
		logic [9:0] quo;
		logic [5:0] rem;
		hi = 17'(v >>> 19);
		a = 16'(hi + 17'sd16470);
		prod = {16'd0, a} * 32'd93207;
		quo = prod[31:22];
		rem = 6'(a - 16'({6'd0, quo} * 16'd45));
		return {rem, v[18:0]};
	endfunction

	// angle update
	logic signed [35:0] sx, sdy, pc;
	logic [24:0] yw, pt;
	always_comb begin
		sx = 36'(delta_x) * $signed({18'd0, sensitivity});
		sdy = 36'(delta_y) * $signed({18'd0, sensitivity});
		yw = wrap_turn(yraw_q);
		pt = wrap_turn(praw_q + 36'(eco_pkg::HALF_TURN));
		pc = praw_q;
		if (pc > 36'(eco_pkg::PITCH_LIMIT)) pc = 36'(eco_pkg::PITCH_LIMIT);
		if (pc < -36'(eco_pkg::PITCH_LIMIT)) pc = -36'(eco_pkg::PITCH_LIMIT);
	end

	// CORDIC range reduction
	logic signed [ZW-1:0] z0;
	logic flip0;
	always_comb begin
		z0 = (cmd.cordic_sel ? ZW'(pitch_q) : ZW'(yaw_q)) <<< 8;
		flip0 = 1'b0;
		if (z0 > ZW'(eco_pkg::Z_HALF)) z0 = z0 - ZW'(2 * eco_pkg::Z_HALF);
		if (z0 < -ZW'(eco_pkg::Z_HALF)) z0 = z0 + ZW'(2 * eco_pkg::Z_HALF);
		if (z0 > ZW'(eco_pkg::Z_QUARTER)) begin
			z0 = z0 - ZW'(eco_pkg::Z_HALF); flip0 = 1'b1;
		end else if (z0 < -ZW'(eco_pkg::Z_QUARTER)) begin
			z0 = z0 + ZW'(eco_pkg::Z_HALF); flip0 = 1'b1;
		end
	end

	logic [4:0] si;
	assign si = 5'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q <= '0;
			pitch_q <= '0;
			step_q <= '0;
			mul_idx_q <= '0;
		end else begin
			if (cmd.wrap) begin
				yaw_q <= yw;
				pitch_q <= lim_q ? 25'(pc) : pt - 25'(eco_pkg::HALF_TURN);
			end
			if (cmd.cordic_init) begin
				x_q <= eco_pkg::CORDIC_GAIN;
				y_q <= '0;
				z_q <= z0;
				flip_q <= flip0;
				step_q <= '0;
			end else if (cmd.cordic_step) begin
				if (z_q >= 0) begin
					x_q <= x_q - (y_q >>> si);
					y_q <= y_q + (x_q >>> si);
					z_q <= z_q - eco_pkg::atan_entry(si);
				end else begin
					x_q <= x_q + (y_q >>> si);
					y_q <= y_q - (x_q >>> si);
					z_q <= z_q + eco_pkg::atan_entry(si);
				end
				step_q <= step_q + 1'b1;
			end
			if (cmd.mul_start) mul_idx_q <= '0;
			else if (cmd.mul_step) mul_idx_q <= mul_idx_q + 3'd1;
		end
	end

	assign sts.cordic_done = (step_q == STEP_W'(CORDIC_STEPS));
	assign sts.mul_done = (mul_idx_q == 3'd4);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yraw_q <= 36'(yaw_q) + sx;
			praw_q <= 36'(pitch_q) + sdy;
			lim_q <= limit_pitch;
		end
		if (cmd.save_yaw) begin
			sy_q <= flip_q ? -y_q : y_q;
			cy_q <= flip_q ? -x_q : x_q;
		end
		if (cmd.save_pitch) begin
			degen_q <= (pitch_q == 25'(eco_pkg::QUARTER_TURN))
				|| (pitch_q == -25'(eco_pkg::QUARTER_TURN));
			if ((pitch_q == 25'(eco_pkg::QUARTER_TURN))
				|| (pitch_q == -25'(eco_pkg::QUARTER_TURN))) begin
				cp_q <= '0;
				sp_q <= pitch_q[24] ? -eco_pkg::Q30_ONE : eco_pkg::Q30_ONE;
			end else begin
				sp_q <= flip_q ? -y_q : y_q;
				cp_q <= flip_q ? -x_q : x_q;
			end
		end
	end

	// one product per cycle: cy*cp, sy*cp, cy*sp, sy*sp
	logic signed [XW-1:0] ma, mb;
	logic signed [2*XW-1:0] mp;
	always_comb begin
		case (mul_idx_q)
			3'd0: begin ma = cy_q; mb = cp_q; end
			3'd1: begin ma = sy_q; mb = cp_q; end
			3'd2: begin ma = cy_q; mb = sp_q; end
			default: begin ma = sy_q; mb = sp_q; end
		endcase
		mp = (2*XW)'(ma) * (2*XW)'(mb) + (2*XW)'(64'sd1 <<< 29);
	end
	always_ff @(posedge clk) begin
		if (cmd.mul_step) p_q[mul_idx_q[1:0]] <= XW'(mp >>> 30);
	end

	function automatic logic [15:0] to_vec(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + XW'(34'sd32768)) >>> 16;
		if (r > XW'(34'sd16384)) r = XW'(34'sd16384);
		if (r < -XW'(34'sd16384)) r = -XW'(34'sd16384);
		return r[15:0];
	endfunction

	logic sgn_neg;
	assign sgn_neg = (pitch_q > 25'(eco_pkg::QUARTER_TURN))
		|| (pitch_q < -25'(eco_pkg::QUARTER_TURN));

	logic [15:0] rx, rz, ux, uy, uz;
	always_comb begin
		if (degen_q) begin
			rx = '0; rz = '0; ux = '0; uy = '0; uz = '0;
		end else begin
			rx = to_vec(sgn_neg ? sy_q : -sy_q);
			rz = to_vec(sgn_neg ? -cy_q : cy_q);
			ux = to_vec(sgn_neg ? p_q[2] : -p_q[2]);
			uy = to_vec(sgn_neg ? -cp_q : cp_q);
			uz = to_vec(sgn_neg ? p_q[3] : -p_q[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish)
			result <= {degen_q, pitch_q, yaw_q, uz, uy, ux, rz, 16'd0, rx,
				to_vec(p_q[1]), to_vec(sp_q), to_vec(p_q[0])};
	end
endmodule

FILE: rtl/eco_ctrl.sv
// Controller state machine sequencing the datapath.
module eco_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  eco_pkg::eco_sts_t sts,
	output eco_pkg::eco_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0, S_WRAP = 3'd1, S_YINIT = 3'd2, S_YRUN = 3'd3,
		S_PINIT = 3'd4, S_PRUN = 3'd5, S_MUL = 3'd6, S_FIN = 3'd7;
	logic [2:0] state_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		case (state_q)
			S_WRAP: cmd.wrap = 1'b1;
			S_YINIT: cmd.cordic_init = 1'b1;
			S_YRUN: begin
				cmd.cordic_step = !sts.cordic_done;
				cmd.save_yaw = sts.cordic_done;
			end
			S_PINIT: begin cmd.cordic_init = 1'b1; cmd.cordic_sel = 1'b1; end
			S_PRUN: begin
				cmd.cordic_step = !sts.cordic_done;
				cmd.save_pitch = sts.cordic_done;
				cmd.mul_start = sts.cordic_done;
			end
			S_MUL: cmd.mul_step = !sts.mul_done;
			// hold the new result until the previous word has drained
			S_FIN: cmd.finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_WRAP;
				S_WRAP: state_q <= S_YINIT;
				S_YINIT: state_q <= S_YRUN;
				S_YRUN: if (sts.cordic_done) state_q <= S_PINIT;
				S_PINIT: state_q <= S_PRUN;
				S_PRUN: if (sts.cordic_done) state_q <= S_MUL;
				S_MUL: if (sts.mul_done) state_q <= S_FIN;
				S_FIN: if (cmd.finish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q) else $error("result dropped");
	a_fin_raises: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> out_valid_q) else $error("result not raised");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE)) else $error("load outside idle");
endmodule

FILE: rtl/euler_camera_orientation.sv
// Top level of the yaw/pitch camera orientation block.
// Usage: each slave word carries one mouse event (delta_x, delta_y, and
// limit_pitch in s_tuser). The block scales the deltas by the sensitivity
// register, updates yaw and pitch, and returns one master word holding the
// front, right and up vectors in Q2.14 plus the new angles and a degenerate
// flag (set in m_tuser) when pitch is exactly plus or minus 90 degrees.
// Sequence from accept to m_tvalid: wrap the angles, then run the one shared
// CORDIC unit first for yaw then for pitch, form four products on the shared
// product unit and build the result. One event is in flight at a time, so a
// new event is accepted only once the last result has been built.
// Reset clears both angles to zero and loads sensitivity with 6554 (0.1).
// When the receiver stalls, the result word holds in its output register;
// the next event is still taken and worked on, and its result waits in the
// last step until the held word drains.
// Write sensitivity through cfg_we/cfg_data only while idle.
module euler_camera_orientation #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [17:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // delta_x, delta_y
	input  logic         s_tuser,  // limit_pitch
	output logic         m_tvalid,
	input  logic         m_tready,
	// front_x,y,z, right_x,y,z, up_x,y,z, yaw_now, pitch_now, zero pad
	output logic [199:0] m_tdata,
	output logic         m_tuser   // degenerate
);
	logic [17:0] sens_q;
	eco_pkg::eco_cmd_t cmd;
	eco_pkg::eco_sts_t sts;
	logic [194:0] res;

	// hold sensitivity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sens_q <= 18'd6554;
		else if (cfg_we) sens_q <= cfg_data;
	end

	eco_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	eco_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.sensitivity(sens_q),
		.delta_x(s_tdata[15:0]), .delta_y(s_tdata[31:16]),
		.limit_pitch(s_tuser), .result(res)
	);

	assign m_tdata = {6'd0, res[193:0]};
	assign m_tuser = res[194];
endmodule
